// ===== hw/rtl/bsfm_pkg.sv =====
// shared types and constants for the battery state-of-charge and fault monitor
// no dependencies
package bsfm_pkg;

  localparam int unsigned MvWidth     = 13;
  localparam int unsigned TenthsWidth = 10;

  // a cell at or below this level counts as absent
  localparam logic [MvWidth-1:0] DeadMv = 13'd100;
  localparam logic [MvWidth-1:0] ThresholdResetMv = 13'd3200;

  localparam logic [TenthsWidth-1:0] HalfCharge = 10'd500;
  localparam logic [TenthsWidth-1:0] FullCharge = 10'd1000;

  // open-circuit-voltage knees of the discharge curve
  localparam logic [MvWidth-1:0] Knee0Mv = 13'd3000;
  localparam logic [MvWidth-1:0] Knee1Mv = 13'd3550;
  localparam logic [MvWidth-1:0] Knee2Mv = 13'd3750;
  localparam logic [MvWidth-1:0] Knee3Mv = 13'd3950;
  localparam logic [MvWidth-1:0] Knee4Mv = 13'd4200;

  localparam logic [TenthsWidth-1:0] Knee1Tenths = 10'd200;
  localparam logic [TenthsWidth-1:0] Knee2Tenths = 10'd500;
  localparam logic [TenthsWidth-1:0] Knee3Tenths = 10'd800;

  // reciprocals for the constant divides, scaled by 2^RecipShift
  localparam int unsigned RecipShift = 16;
  localparam logic [12:0] RecipEleven = 13'd5958;
  localparam logic [13:0] RecipFive   = 14'd13108;

  typedef enum logic [1:0] {
    MODE_IDLE      = 2'd0,
    MODE_CHARGE    = 2'd1,
    MODE_DISCHARGE = 2'd2,
    MODE_FAULT     = 2'd3
  } mode_e;

endpackage

// ===== hw/rtl/bsfm_soc_map.sv =====
// open-circuit-voltage to state-of-charge map, piecewise linear, combinational
// depends on bsfm_pkg
module bsfm_soc_map import bsfm_pkg::*; (
  input  logic [MvWidth-1:0]     avg_mv_i,
  output logic [TenthsWidth-1:0] tenths_o
);

  logic [MvWidth-1:0] d0, d1, d2, d3;
  logic [25:0] prod0;
  logic [25:0] prod3;
  logic [10:0] lin12;
  logic [TenthsWidth-1:0] seg0, seg1, seg2, seg3;

  assign d0 = avg_mv_i - Knee0Mv;
  assign d1 = avg_mv_i - Knee1Mv;
  assign d2 = avg_mv_i - Knee2Mv;
  assign d3 = avg_mv_i - Knee3Mv;

  // 200/550 = 4/11, exact through the reciprocal for these spans
  assign prod0 = {d0[9:0], 2'b00} * RecipEleven;
  assign seg0  = prod0[RecipShift +: TenthsWidth];

  // 300/200 = 3/2
  assign lin12 = 11'({d1[7:0], 1'b0} + {1'b0, d1[7:0]});
  assign seg1  = Knee1Tenths + 10'(lin12[10:1]);

  logic [10:0] lin23;
  assign lin23 = 11'({d2[7:0], 1'b0} + {1'b0, d2[7:0]});
  assign seg2  = Knee2Tenths + 10'(lin23[10:1]);

  // 200/250 = 4/5
  assign prod3 = {d3[7:0], 2'b00} * RecipFive;
  assign seg3  = Knee3Tenths + prod3[RecipShift +: TenthsWidth];

  always_comb begin
    if (avg_mv_i <= Knee0Mv) begin
      tenths_o = '0;
    end else if (avg_mv_i >= Knee4Mv) begin
      tenths_o = FullCharge;
    end else if (avg_mv_i < Knee1Mv) begin
      tenths_o = seg0;
    end else if (avg_mv_i < Knee2Mv) begin
      tenths_o = seg1;
    end else if (avg_mv_i < Knee3Mv) begin
      tenths_o = seg2;
    end else begin
      tenths_o = seg3;
    end
  end

endmodule

// ===== hw/rtl/battery_soc_and_fault_monitor_core.sv =====
// top level of the battery state-of-charge and undervoltage fault monitor
// depends on bsfm_pkg and bsfm_soc_map
//
// One transaction carries two cell voltages in mV and yields one result: state of
// charge in tenths of a percent, operating mode, relay state and three mode LEDs.
// The block takes one transaction per clock unless the result channel stalls;
// an accepted transaction moves from the input register through the single compute
// stage into the result register, which also holds the running charge level.
// The undervoltage threshold resets to 3200 mV and a value of 0 disables faults;
// the user must write it through cfg_we_i / cfg_wdata_i only while no transaction
// is in flight, as the block itself does not enforce this.
module battery_soc_and_fault_monitor_core import bsfm_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration
  input  logic                   cfg_we_i,
  input  logic [MvWidth-1:0]     cfg_wdata_i,
  // sample channel
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [MvWidth-1:0]     cell_one_mv_i,
  input  logic [MvWidth-1:0]     cell_two_mv_i,
  // result channel
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [TenthsWidth-1:0] charge_tenths_o,
  output logic [1:0]             mode_o,
  output logic                   relay_closed_o,
  output logic                   led_charge_o,
  output logic                   led_discharge_o,
  output logic                   led_fault_o
);

  // threshold register
  logic [MvWidth-1:0] threshold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= ThresholdResetMv;
    end else if (cfg_we_i) begin
      threshold_q <= cfg_wdata_i;
    end
  end

  // handshake: the input stage moves on whenever the result register is free
  logic in_valid_q, out_valid_q;
  logic advance, accept;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  logic [MvWidth-1:0] cell_one_q, cell_two_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cell_one_q <= cell_one_mv_i;
      cell_two_q <= cell_two_mv_i;
    end
  end

  // compute stage: average, charge map, fault check
  logic [MvWidth:0]       cell_sum;
  logic [MvWidth-1:0]     avg_mv;
  logic [TenthsWidth-1:0] mapped_tenths;
  logic [TenthsWidth-1:0] charge_q, charge_d;
  logic                   one_low, two_low, fault;
  mode_e                  mode_d, mode_q;
  logic                   relay_q;

  assign cell_sum = {1'b0, cell_one_q} + {1'b0, cell_two_q};
  assign avg_mv   = cell_sum[MvWidth:1];

  bsfm_soc_map u_soc_map (
    .avg_mv_i (avg_mv),
    .tenths_o (mapped_tenths)
  );

  // a near-zero average means no usable reading: hold the last charge
  assign charge_d = (avg_mv > DeadMv) ? mapped_tenths : charge_q;

  // a dead cell never raises a fault
  assign one_low = (cell_one_q > DeadMv) && (cell_one_q < threshold_q);
  assign two_low = (cell_two_q > DeadMv) && (cell_two_q < threshold_q);
  assign fault   = one_low || two_low;

  always_comb begin
    if (fault) begin
      mode_d = MODE_FAULT;
    end else if (charge_d > HalfCharge) begin
      mode_d = MODE_CHARGE;
    end else begin
      mode_d = MODE_DISCHARGE;
    end
  end

  // result register, also the running charge level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      charge_q    <= FullCharge;
      mode_q      <= MODE_IDLE;
      relay_q     <= 1'b1;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
      if (in_valid_q) begin
        charge_q <= charge_d;
        mode_q   <= mode_d;
        relay_q  <= !fault;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign charge_tenths_o = charge_q;
  assign mode_o          = mode_q;
  assign relay_closed_o  = relay_q;
  assign led_charge_o    = (mode_q == MODE_CHARGE);
  assign led_discharge_o = (mode_q == MODE_DISCHARGE);
  assign led_fault_o     = (mode_q == MODE_FAULT);

endmodule
